// ----- src/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the bounded circular deque
// Payload structs, operation codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned CAP_W  = 7;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RST = 7'd64;

  // operation codes; codes 5..7 behave as a query
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_FRONT = 3'd0,
    FUNC_INS_REAR  = 3'd1,
    FUNC_DEL_FRONT = 3'd2,
    FUNC_DEL_REAR  = 3'd3,
    FUNC_QUERY     = 3'd4
  } func_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  // input word
  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
  } in_t;

  // result word
  typedef struct packed {
    logic                     succeeded;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // apply the accepted operation
    logic rd_en;  // read front and rear entries
    logic load;   // load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new word this cycle
    logic res_held;  // result register holds a word not yet taken
  } ctrl_sts_t;

endpackage

// ----- src/bounded_circular_deque_core.sv -----
// After an input is accepted the controller reads the store, then loads the result
// register, waiting while it is still occupied; a new word is taken only in idle.
// The ring store is single-write, two-read; the next word is taken while a result waits.
// Capacity writes are taken only in idle with no result pending, ahead of an input.
// Reset: count and front pointer cleared, capacity 64, rear pointer at capacity
// minus one; store contents stay undefined until written.
// ----------------------------------------------------------------------------
// bounded_circular_deque_core: bounded double-ended queue of 32-bit words
// Insert or remove at either end, or query; each word returns one result with
// success, front and rear words, and empty and full flags.
// ----------------------------------------------------------------------------
module bounded_circular_deque_core #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bcd_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bcd_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bcd_pkg::CAP_W-1:0] cfg_data_i
);

  bcd_pkg::ctrl_cmd_t cmd;
  bcd_pkg::ctrl_sts_t sts;

  bcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // one word in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous word in flight");

  // empty result shows -1 at both ends
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.front_word == '1 && out_data_o.rear_word == '1)
    else $error("empty result with stale words");

  // capacity is at least one, so empty and full never coincide
  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_empty && out_data_o.is_full))
    else $error("result both empty and full");
`endif

endmodule

// ----- src/bcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcd_ctrl: operation sequencer
// Accepts one word, then steps through the store read and the result load,
// waiting in the load step while the result register is still occupied.
// Capacity writes are taken only in idle with no result pending.
// ----------------------------------------------------------------------------
module bcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  bcd_pkg::ctrl_sts_t   sts_i,
  output bcd_pkg::ctrl_cmd_t   cmd_o
);

  bcd_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state; a pending capacity write goes first
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcd_pkg::ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i) state_d = bcd_pkg::ST_READ;
      end
      bcd_pkg::ST_READ: begin
        state_d = bcd_pkg::ST_LOAD;
      end
      bcd_pkg::ST_LOAD: begin
        if (sts_i.out_free) state_d = bcd_pkg::ST_IDLE;
      end
      default: begin
        state_d = bcd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      bcd_pkg::ST_IDLE: begin
        cfg_ready_o = !sts_i.res_held;
        in_ready_o  = !cfg_valid_i;
        cmd_o.exec  = in_valid_i && !cfg_valid_i;
      end
      bcd_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      bcd_pkg::ST_LOAD: begin
        cmd_o.load = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/bcd_dp.sv -----
// ----------------------------------------------------------------------------
// bcd_dp: deque datapath
// Ring store, front and rear pointers, entry count, capacity register and
// the result register.
// ----------------------------------------------------------------------------
module bcd_dp #(
  parameter int DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bcd_pkg::in_t                  in_data_i,
  input  logic                          cfg_we_i,
  input  logic [bcd_pkg::CAP_W-1:0]     cfg_data_i,
  input  bcd_pkg::ctrl_cmd_t            cmd_i,
  output bcd_pkg::ctrl_sts_t            sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bcd_pkg::out_t                 out_data_o
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RST_CAP = (DEPTH < int'(bcd_pkg::CAP_RST)) ? DEPTH : int'(bcd_pkg::CAP_RST);

  // effective capacity: the register value limited to 1..DEPTH
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [bcd_pkg::CAP_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (32'(c) > DEPTH) begin
      return CNT_W'(DEPTH);
    end else begin
      return CNT_W'(c);
    end
  endfunction

  // pointer advance, wrapping at the effective capacity
  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(p) + CNT_W'(1);
    return (nxt >= c) ? '0 : PTR_W'(nxt);
  endfunction

  // pointer retreat, wrapping to capacity minus one
  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] c);
    return (p == '0) ? PTR_W'(c - CNT_W'(1)) : p - PTR_W'(1);
  endfunction

  logic [bcd_pkg::CAP_W-1:0] cap_q;
  logic [PTR_W-1:0]          front_q, front_d;
  logic [PTR_W-1:0]          rear_q, rear_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ok_q, ok_d;
  logic [CNT_W-1:0]          eff_cap;
  logic [CNT_W-1:0]          cfg_eff;
  logic                      full, empty;
  logic                      we;
  logic [PTR_W-1:0]          waddr;

  logic signed [bcd_pkg::WORD_W-1:0] mem [DEPTH];
  logic signed [bcd_pkg::WORD_W-1:0] rd_front_q, rd_rear_q;

  logic          out_valid_q;
  bcd_pkg::out_t out_q;

  assign eff_cap = clamp_cap(cap_q);
  assign cfg_eff = clamp_cap(cfg_data_i);
  assign full    = (cnt_q >= eff_cap);
  assign empty   = (cnt_q == '0);

  // operation decode and pointer update
  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    cnt_d   = cnt_q;
    ok_d    = 1'b1;
    we      = 1'b0;
    waddr   = front_q;
    case (bcd_pkg::func_e'(in_data_i.func))
      bcd_pkg::FUNC_INS_FRONT: begin
        if (full) begin
          ok_d = 1'b0;
        end else begin
          front_d = step_down(front_q, eff_cap);
          waddr   = front_d;
          we      = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      bcd_pkg::FUNC_INS_REAR: begin
        if (full) begin
          ok_d = 1'b0;
        end else begin
          rear_d = step_up(rear_q, eff_cap);
          waddr  = rear_d;
          we     = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      bcd_pkg::FUNC_DEL_FRONT: begin
        if (empty) begin
          ok_d = 1'b0;
        end else begin
          front_d = step_up(front_q, eff_cap);
          cnt_d   = cnt_q - CNT_W'(1);
        end
      end
      bcd_pkg::FUNC_DEL_REAR: begin
        if (empty) begin
          ok_d = 1'b0;
        end else begin
          rear_d = step_down(rear_q, eff_cap);
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        ok_d = 1'b1;
      end
    endcase
  end

  // pointers, count and capacity; capacity write takes effect only when empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= bcd_pkg::CAP_RST;
      front_q <= '0;
      rear_q  <= PTR_W'(RST_CAP - 1);
      cnt_q   <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      cnt_q   <= cnt_d;
    end else if (cfg_we_i && empty) begin
      cap_q   <= cfg_data_i;
      front_q <= '0;
      rear_q  <= PTR_W'(cfg_eff - CNT_W'(1));
    end
  end

  // status of the operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) ok_q <= ok_d;
  end

  // ring store: one write port, front and rear read with registered data
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem[waddr] <= in_data_i.value;
    if (cmd_i.rd_en) begin
      rd_front_q <= mem[front_q];
      rd_rear_q  <= mem[rear_q];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.succeeded  <= ok_q;
      out_q.front_word <= empty ? '1 : rd_front_q;
      out_q.rear_word  <= empty ? '1 : rd_rear_q;
      out_q.is_empty   <= empty;
      out_q.is_full    <= full;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.res_held = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ----- tb/bounded_circular_deque_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_circular_deque_core_tb: self-checking bench for the deque core
// A directed table covers empty and full refusals, word extremes, the unused
// operation codes and capacity writes at and beyond the limits. Random
// fill/drain sequences follow at several capacities. Each result word is
// checked field by field against its typed row or the bench's ring model.
// ----------------------------------------------------------------------------
module bounded_circular_deque_core_tb;

  localparam int          CLK_PERIOD  = 4;
  localparam int          RING_DEPTH  = 64;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_AT     = 120;   // results seen before the long stall
  localparam int          HOLD_LEN    = 200;
  localparam int          SETTLE      = 10;
  localparam int          IDLE_PCT    = 30;
  localparam int          NSEG        = 7;
  localparam logic [31:0] NONE_W      = 32'hFFFF_FFFF;  // front/rear when empty
  localparam logic [31:0] W_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN       = 32'h8000_0000;

  // operation codes with no name in the package; they behave as a query
  localparam logic [bcd_pkg::FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [bcd_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [bcd_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct {
    bit                        is_cfg;
    bcd_pkg::in_t              word;
    logic [bcd_pkg::CAP_W-1:0] cap;
    bit                        typed;
    bcd_pkg::out_t             want;
  } plan_row_t;

  // DUT signals; the inputs are known from time zero
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  bcd_pkg::in_t              in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  bcd_pkg::out_t             out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [bcd_pkg::CAP_W-1:0] cfg_data_i  = '0;

  // deque model state
  logic [bcd_pkg::WORD_W-1:0] ring [RING_DEPTH];
  logic [5:0]                 fptr;
  logic [5:0]                 rptr;
  logic [bcd_pkg::CAP_W-1:0]  occ;
  logic [bcd_pkg::CAP_W-1:0]  cap_reg;

  bcd_pkg::out_t             results_due [$];
  plan_row_t                 plan [$];
  logic [bcd_pkg::CAP_W-1:0] seg_cap [NSEG];
  int                        seg_len [NSEG];
  bcd_pkg::out_t             rx_want;

  bit quiet;
  bit in_up;
  bit cfg_up;
  bit held;
  int hold_left;
  int cycles;
  int errors;
  int results_got;
  int ops_sent;
  int refused;
  int full_seen;
  int cap_writes;

  bounded_circular_deque_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // capacity in force: zero acts as one, anything above the ring size as the ring size
  function automatic logic [bcd_pkg::CAP_W-1:0] live_cap();
    if (cap_reg == '0) return 7'd1;
    if (cap_reg > RING_DEPTH) return 7'(RING_DEPTH);
    return cap_reg;
  endfunction

  // apply one operation to the model and return the result word it gives
  function automatic bcd_pkg::out_t deque_apply(input bcd_pkg::in_t w);
    logic [bcd_pkg::CAP_W-1:0] c;
    bit                        ok;
    bcd_pkg::out_t             r;
    c  = live_cap();
    ok = 1'b1;
    case (w.func)
      bcd_pkg::FUNC_INS_FRONT: begin
        if (occ >= c) begin
          ok = 1'b0;
        end else begin
          fptr = (fptr == '0) ? 6'(c - 7'd1) : fptr - 6'd1;
          ring[fptr] = w.value;
          occ++;
        end
      end
      bcd_pkg::FUNC_INS_REAR: begin
        if (occ >= c) begin
          ok = 1'b0;
        end else begin
          rptr = (7'(rptr) + 7'd1 >= c) ? '0 : rptr + 6'd1;
          ring[rptr] = w.value;
          occ++;
        end
      end
      bcd_pkg::FUNC_DEL_FRONT: begin
        if (occ == '0) begin
          ok = 1'b0;
        end else begin
          fptr = (7'(fptr) + 7'd1 >= c) ? '0 : fptr + 6'd1;
          occ--;
        end
      end
      bcd_pkg::FUNC_DEL_REAR: begin
        if (occ == '0) begin
          ok = 1'b0;
        end else begin
          rptr = (rptr == '0) ? 6'(c - 7'd1) : rptr - 6'd1;
          occ--;
        end
      end
      default: ;  // query and unused codes change nothing
    endcase
    r.succeeded  = ok;
    r.is_empty   = (occ == '0);
    r.is_full    = (occ >= c);
    r.front_word = r.is_empty ? NONE_W : ring[fptr];
    r.rear_word  = r.is_empty ? NONE_W : ring[rptr];
    if (!ok) refused++;
    if (r.is_full) full_seen++;
    return r;
  endfunction

  function automatic bcd_pkg::out_t outcome(input bit ok,
                                            input logic [bcd_pkg::WORD_W-1:0] fw,
                                            input logic [bcd_pkg::WORD_W-1:0] rw,
                                            input bit e, input bit f);
    bcd_pkg::out_t r;
    r.succeeded  = ok;
    r.front_word = fw;
    r.rear_word  = rw;
    r.is_empty   = e;
    r.is_full    = f;
    return r;
  endfunction

  function automatic plan_row_t op_row(input logic [bcd_pkg::FUNC_W-1:0] f,
                                       input logic [bcd_pkg::WORD_W-1:0] v);
    plan_row_t r;
    r.is_cfg     = 1'b0;
    r.word.func  = f;
    r.word.value = v;
    r.cap        = '0;
    r.typed      = 1'b0;
    r.want       = '0;
    return r;
  endfunction

  function automatic plan_row_t chk_row(input logic [bcd_pkg::FUNC_W-1:0] f,
                                        input logic [bcd_pkg::WORD_W-1:0] v,
                                        input bcd_pkg::out_t want);
    plan_row_t r;
    r       = op_row(f, v);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t cap_row(input logic [bcd_pkg::CAP_W-1:0] c);
    plan_row_t r;
    r        = op_row(bcd_pkg::FUNC_QUERY, '0);
    r.is_cfg = 1'b1;
    r.cap    = c;
    return r;
  endfunction

  // append one row to the directed table
  task automatic add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endtask

  // random word: mostly inserts while growing, mostly removes while shrinking
  function automatic bcd_pkg::in_t rand_word(input bit grow);
    bcd_pkg::in_t w;
    int           roll;
    roll    = $urandom_range(99);
    w.value = $urandom();
    if (roll < 10) begin
      w.func = 3'($urandom_range(7));
    end else if ((roll < 85) == grow) begin
      w.func = $urandom_range(1) ? bcd_pkg::FUNC_INS_REAR : bcd_pkg::FUNC_INS_FRONT;
    end else begin
      w.func = $urandom_range(1) ? bcd_pkg::FUNC_DEL_REAR : bcd_pkg::FUNC_DEL_FRONT;
    end
    return w;
  endfunction

  // drop the input valid and wait until every pending result has come back
  task automatic wait_drained();
    if (in_up) begin
      in_valid_i <= 1'b0;
      in_up = 1'b0;
    end
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // offer one operation word, record its expected result on acceptance
  task automatic offer(input bcd_pkg::in_t w, input bit typed, input bcd_pkg::out_t given);
    bcd_pkg::out_t pred;
    if (cfg_up) begin
      cfg_valid_i <= 1'b0;
      cfg_up = 1'b0;
    end
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      if (in_up) begin
        in_valid_i <= 1'b0;
        in_up = 1'b0;
      end
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    in_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pred = deque_apply(w);
    results_due.insert(results_due.size(), typed ? given : pred);
    ops_sent++;
  endtask

  // capacity write; ignored by the block unless the deque is empty
  task automatic write_cap(input logic [bcd_pkg::CAP_W-1:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    cfg_up = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_writes++;
    if (occ == '0) begin
      cap_reg = v;
      fptr    = '0;
      rptr    = 6'(live_cap() - 7'd1);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // result side: check each accepted word, drive ready with random stalls
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_got++;
      if (results_due.size() == 0) begin
        errors++;
        $error("result word %h with nothing pending", out_data_o);
      end else begin
        rx_want = results_due[0];
        results_due.delete(0);
        check_field("succeeded", 32'(rx_want.succeeded), 32'(out_data_o.succeeded));
        check_field("front_word", rx_want.front_word, out_data_o.front_word);
        check_field("rear_word", rx_want.rear_word, out_data_o.rear_word);
        check_field("is_empty", 32'(rx_want.is_empty), 32'(out_data_o.is_empty));
        check_field("is_full", 32'(rx_want.is_full), 32'(out_data_o.is_full));
      end
    end
    // one long hold-off lets the core back up into its input
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!held && results_got >= HOLD_AT) begin
      held      = 1'b1;
      hold_left = HOLD_LEN;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit           grow;
    bcd_pkg::in_t pop_w;

    cap_reg = bcd_pkg::CAP_RST;
    fptr    = '0;
    occ     = '0;
    rptr    = 6'(live_cap() - 7'd1);

    // directed table: typed results where they follow directly from the spec
    add_row(chk_row(bcd_pkg::FUNC_QUERY, 32'h0,
                    outcome(1'b1, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(chk_row(bcd_pkg::FUNC_DEL_FRONT, 32'h0,
                    outcome(1'b0, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(chk_row(bcd_pkg::FUNC_DEL_REAR, 32'h0,
                    outcome(1'b0, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(chk_row(FUNC_SPARE_7, 32'h0,
                    outcome(1'b1, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(chk_row(bcd_pkg::FUNC_INS_FRONT, W_MAX,
                    outcome(1'b1, W_MAX, W_MAX, 1'b0, 1'b0)));
    add_row(chk_row(bcd_pkg::FUNC_INS_REAR, W_MIN,
                    outcome(1'b1, W_MAX, W_MIN, 1'b0, 1'b0)));
    add_row(chk_row(bcd_pkg::FUNC_INS_FRONT, NONE_W,
                    outcome(1'b1, NONE_W, W_MIN, 1'b0, 1'b0)));
    add_row(op_row(bcd_pkg::FUNC_INS_REAR, 32'h0));
    add_row(cap_row(7'd5));            // not empty: write is dropped
    add_row(op_row(FUNC_SPARE_5, 32'hDEAD_BEEF));
    add_row(op_row(FUNC_SPARE_6, 32'h0BAD_F00D));
    add_row(op_row(bcd_pkg::FUNC_DEL_FRONT, 32'h0));
    add_row(op_row(bcd_pkg::FUNC_DEL_REAR, 32'h0));
    add_row(op_row(bcd_pkg::FUNC_DEL_FRONT, 32'h0));
    add_row(chk_row(bcd_pkg::FUNC_DEL_REAR, 32'h0,
                    outcome(1'b1, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(cap_row(7'd1));
    add_row(chk_row(bcd_pkg::FUNC_INS_REAR, 32'h1234_5678,
                    outcome(1'b1, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1)));
    add_row(chk_row(bcd_pkg::FUNC_INS_FRONT, 32'h0000_0055,
                    outcome(1'b0, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1)));
    add_row(chk_row(bcd_pkg::FUNC_DEL_REAR, 32'h0,
                    outcome(1'b1, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(cap_row(7'd0));            // zero acts as one
    add_row(chk_row(bcd_pkg::FUNC_INS_FRONT, 32'hAAAA_AAAA,
                    outcome(1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1)));
    add_row(chk_row(bcd_pkg::FUNC_INS_REAR, 32'h0000_0001,
                    outcome(1'b0, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1)));
    add_row(chk_row(bcd_pkg::FUNC_DEL_FRONT, 32'h0,
                    outcome(1'b1, NONE_W, NONE_W, 1'b1, 1'b0)));
    add_row(cap_row(7'd127));          // above the ring size
    add_row(op_row(bcd_pkg::FUNC_INS_REAR, 32'h5555_5555));
    add_row(op_row(bcd_pkg::FUNC_INS_FRONT, 32'h0));

    // random phases: capacity and length of each
    seg_cap = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd2, 7'd10, 7'd64};
    seg_len = '{190, 80, 40, 120, 60, 80, 80};
    seg_cap[NSEG-1] = 7'($urandom_range(4, RING_DEPTH));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_cap(plan[i].cap);
      else offer(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int s = 0; s < NSEG; s++) begin
      // empty the deque so the new capacity takes effect
      while (occ != '0) begin
        pop_w.func  = bcd_pkg::FUNC_DEL_FRONT;
        pop_w.value = $urandom();
        offer(pop_w, 1'b0, '0);
      end
      write_cap(seg_cap[s]);
      quiet = (s == 1);
      grow  = 1'b1;
      for (int n = 0; n < seg_len[s]; n++) begin
        // swap direction a few words after hitting full or empty
        if (grow && occ == live_cap() && $urandom_range(3) == 0) grow = 1'b0;
        else if (!grow && occ == '0 && $urandom_range(3) == 0) grow = 1'b1;
        offer(rand_word(grow), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d operations (%0d refused, %0d full results), %0d capacity writes",
             ops_sent, refused, full_seen, cap_writes);
    $display("checked %0d result words, %0d field mismatches", results_got, errors);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bcd_pkg.sv
src/bcd_ctrl.sv
src/bcd_dp.sv
src/bounded_circular_deque_core.sv
tb/bounded_circular_deque_core_tb.sv
